FILE: rtl/core/adsr_pkg.sv
package adsr_pkg;

	localparam int LEN_BITS_DEF        = 20;
	localparam int LEVEL_FRAC_BITS_DEF = 15;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME   = 3'd4;

	localparam int ATTACK_RST  = 480;
	localparam int DECAY_RST   = 4800;
	localparam int RELEASE_RST = 4800;
	localparam int SUSTAIN_RST = 16384;
	localparam int FRAME_RST   = 48000;

	// envelope phase codes
	localparam logic [2:0] PH_ATTACK  = 3'd0;
	localparam logic [2:0] PH_DECAY   = 3'd1;
	localparam logic [2:0] PH_SUSTAIN = 3'd2;
	localparam logic [2:0] PH_RELEASE = 3'd3;
	localparam logic [2:0] PH_TAIL    = 3'd4;

	// sequencer step addresses
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] ST_CHK_A = 3'd1;
	localparam logic [STEP_W-1:0] ST_CHK_D = 3'd2;
	localparam logic [STEP_W-1:0] ST_CHK_S = 3'd3;
	localparam logic [STEP_W-1:0] ST_CHK_R = 3'd4;
	localparam logic [STEP_W-1:0] ST_MUL   = 3'd5;
	localparam logic [STEP_W-1:0] ST_DIV   = 3'd6;
	localparam logic [STEP_W-1:0] ST_OUT   = 3'd7;
	localparam int UCODE_DEPTH = 8;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_HIT,
		COND_DIV_DONE,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_CHECK,
		ACT_MUL,
		ACT_DIV,
		ACT_OUT
	} act_t;

	typedef enum logic [1:0] {
		BND_NONE,
		BND_ADD_D,
		BND_MAX_FR,
		BND_ADD_R
	} bnd_op_t;

	typedef struct packed {
		cond_t              cond;
		act_t               act;
		bnd_op_t            bnd;
		logic [2:0]         ph;
		logic [STEP_W-1:0]  tgt;
		logic [STEP_W-1:0]  nxt;
	} uword_t;

	typedef struct packed {
		uword_t w;
		logic   fire;
	} ctrl_t;

	typedef struct packed {
		logic hit;
		logic div_last;
		logic out_free;
	} status_t;

	localparam uword_t UCODE [UCODE_DEPTH] = '{
		'{COND_IN_VALID, ACT_LOAD,  BND_NONE,   PH_ATTACK,  ST_IDLE, ST_CHK_A},
		'{COND_HIT,      ACT_CHECK, BND_ADD_D,  PH_ATTACK,  ST_MUL,  ST_CHK_D},
		'{COND_HIT,      ACT_CHECK, BND_MAX_FR, PH_DECAY,   ST_MUL,  ST_CHK_S},
		'{COND_HIT,      ACT_CHECK, BND_ADD_R,  PH_SUSTAIN, ST_OUT,  ST_CHK_R},
		'{COND_HIT,      ACT_CHECK, BND_NONE,   PH_RELEASE, ST_MUL,  ST_OUT},
		'{COND_ALWAYS,   ACT_MUL,   BND_NONE,   PH_TAIL,    ST_DIV,  ST_DIV},
		'{COND_DIV_DONE, ACT_DIV,   BND_NONE,   PH_TAIL,    ST_OUT,  ST_OUT},
		'{COND_OUT_FREE, ACT_OUT,   BND_NONE,   PH_TAIL,    ST_IDLE, ST_IDLE}
	};

endpackage

FILE: rtl/core/adsr_cfg_regs.sv
module adsr_cfg_regs #(
	parameter int LEN_BITS        = adsr_pkg::LEN_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int CFG_W           = LEN_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]               cfg_data,
	output logic [LEN_BITS-1:0]            attack_len,
	output logic [LEN_BITS-1:0]            decay_len,
	output logic [LEN_BITS-1:0]            release_len,
	output logic [LEVEL_FRAC_BITS:0]       sustain_eff,
	output logic [LEN_BITS:0]              frame_eff
);
	import adsr_pkg::*;

	localparam int SW = LEVEL_FRAC_BITS + 1;
	localparam logic [SW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	logic [LEN_BITS-1:0] attack_q, decay_q, release_q;
	logic [SW-1:0]       sustain_q;
	logic [LEN_BITS:0]   frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= LEN_BITS'(ATTACK_RST);
			decay_q   <= LEN_BITS'(DECAY_RST);
			release_q <= LEN_BITS'(RELEASE_RST);
			sustain_q <= SW'(SUSTAIN_RST);
			frame_q   <= (LEN_BITS + 1)'(FRAME_RST);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ATTACK:  attack_q  <= cfg_data[LEN_BITS-1:0];
				REG_DECAY:   decay_q   <= cfg_data[LEN_BITS-1:0];
				REG_RELEASE: release_q <= cfg_data[LEN_BITS-1:0];
				REG_SUSTAIN: sustain_q <= cfg_data[SW-1:0];
				REG_FRAME:   frame_q   <= cfg_data[LEN_BITS:0];
				default: ;
			endcase
		end
	end

	assign attack_len  = attack_q;
	assign decay_len   = decay_q;
	assign release_len = release_q;
	// clamp sustain to full scale, treat an empty frame as one sample
	assign sustain_eff = (sustain_q > FULL) ? FULL : sustain_q;
	assign frame_eff   = (frame_q == '0) ? (LEN_BITS + 1)'(1) : frame_q;

endmodule

FILE: rtl/core/adsr_sequencer.sv
module adsr_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  adsr_pkg::status_t status,
	output adsr_pkg::ctrl_t   ctrl
);
	import adsr_pkg::*;

	logic [STEP_W-1:0] step_q;
	uword_t            w;
	logic              fire;

	assign w = UCODE[step_q];

	always_comb begin
		case (w.cond)
			COND_IN_VALID: fire = in_valid;
			COND_OUT_FREE: fire = status.out_free;
			default:       fire = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			case (w.cond)
				COND_HIT:      step_q <= status.hit ? w.tgt : w.nxt;
				COND_DIV_DONE: step_q <= status.div_last ? w.nxt : step_q;
				default:       step_q <= fire ? w.nxt : step_q;
			endcase
		end
	end

	assign ctrl.w    = w;
	assign ctrl.fire = fire;

endmodule

FILE: rtl/core/adsr_datapath.sv
module adsr_datapath #(
	parameter int LEN_BITS        = adsr_pkg::LEN_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  adsr_pkg::ctrl_t          ctrl,
	output adsr_pkg::status_t        status,
	input  logic                     start_req,
	input  logic [LEN_BITS-1:0]      attack_len,
	input  logic [LEN_BITS-1:0]      decay_len,
	input  logic [LEN_BITS-1:0]      release_len,
	input  logic [LEVEL_FRAC_BITS:0] sustain_eff,
	input  logic [LEN_BITS:0]        frame_eff,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [LEVEL_FRAC_BITS:0] level,
	output logic                     last,
	output logic [2:0]               phase
);
	import adsr_pkg::*;

	localparam int SW = LEVEL_FRAC_BITS + 1;
	localparam int IW = LEN_BITS + 1;
	localparam int BW = LEN_BITS + 2;
	localparam int PW = LEN_BITS + SW;
	localparam int CW = $clog2(SW);
	localparam logic [SW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	logic [IW-1:0]       frame_idx_q;
	logic [IW-1:0]       idx_q;
	logic [BW-1:0]       base_q, bnd_q;
	logic [2:0]          ph_q;
	logic [LEN_BITS-1:0] pos_q, div_q;
	logic [LEN_BITS-1:0] rem_q;
	logic [SW-1:0]       nq_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q, last_q;
	logic [SW-1:0]       level_q;
	logic [2:0]          phase_q;

	logic                hit;
	logic [BW-1:0]       pos_d, sum_r, r_ext, f_ext, bnd_next;
	logic [LEN_BITS-1:0] div_sel;
	logic [SW-1:0]       k;
	logic [PW-1:0]       prod;
	logic [LEN_BITS:0]   trial, diff;
	logic                ge;
	logic [SW-1:0]       lvl;
	logic                frame_end;
	logic                out_free;

	// phase boundary walk
	assign hit   = BW'(idx_q) < bnd_q;
	assign pos_d = BW'(idx_q) - base_q;
	assign r_ext = BW'(release_len);
	assign f_ext = BW'(frame_eff);
	assign sum_r = bnd_q + r_ext;

	always_comb begin
		case (ctrl.w.bnd)
			BND_ADD_D:  bnd_next = bnd_q + BW'(decay_len);
			// sustain ends at frame minus release, or right after decay when that is not past the decay end
			BND_MAX_FR: bnd_next = (f_ext > sum_r) ? f_ext - r_ext : bnd_q;
			BND_ADD_R:  bnd_next = sum_r;
			default:    bnd_next = bnd_q;
		endcase
	end

	always_comb begin
		case (ctrl.w.ph)
			PH_ATTACK: div_sel = attack_len;
			PH_DECAY:  div_sel = decay_len;
			default:   div_sel = release_len;
		endcase
	end

	always_comb begin
		case (ph_q)
			PH_ATTACK: k = FULL;
			PH_DECAY:  k = FULL - sustain_eff;
			default:   k = sustain_eff;
		endcase
	end

	assign prod = PW'(pos_q) * PW'(k);

	// one restoring step per cycle, quotient bits shift in at the bottom
	assign trial = {rem_q, nq_q[SW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_comb begin
		case (ph_q)
			PH_ATTACK:  lvl = nq_q;
			PH_DECAY:   lvl = FULL - nq_q;
			PH_SUSTAIN: lvl = sustain_eff;
			PH_RELEASE: lvl = sustain_eff - nq_q;
			default:    lvl = '0;
		endcase
	end

	assign frame_end = idx_q >= frame_eff - IW'(1);
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		case (ctrl.w.act)
			ACT_LOAD: begin
				if (ctrl.fire) begin
					idx_q  <= start_req ? '0 : frame_idx_q;
					base_q <= '0;
					bnd_q  <= BW'(attack_len);
				end
			end
			ACT_CHECK: begin
				if (hit) begin
					ph_q  <= ctrl.w.ph;
					pos_q <= pos_d[LEN_BITS-1:0];
					div_q <= div_sel;
				end else begin
					ph_q   <= PH_TAIL;
					base_q <= bnd_q;
					bnd_q  <= bnd_next;
				end
			end
			ACT_MUL: begin
				rem_q <= prod[PW-1:SW];
				nq_q  <= prod[SW-1:0];
				cnt_q <= '0;
			end
			ACT_DIV: begin
				rem_q <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
				nq_q  <= {nq_q[SW-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.w.act == ACT_OUT && ctrl.fire) begin
			level_q <= lvl;
			phase_q <= ph_q;
			last_q  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.w.act == ACT_OUT && ctrl.fire) begin
				out_valid_q <= 1'b1;
				frame_idx_q <= frame_end ? '0 : idx_q + IW'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.hit      = hit;
	assign status.div_last = cnt_q == CW'(SW - 1);
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign last      = last_q;
	assign phase     = phase_q;

endmodule

FILE: rtl/core/adsr_envelope_generator.sv
// Each input sample is loaded, checked against the phase bounds, scaled by the multiply and
// the divide, and output; sustain and tail samples skip the divide.
// A new input is taken only once the previous sample has been output; each divide runs on the
// one-bit-per-cycle restoring divider stepped by the control program.
// Reset clears the step counter, the frame index and the output valid flag, and
// loads the configuration registers with their default lengths and levels.
module adsr_envelope_generator #(
	parameter int LEN_BITS        = adsr_pkg::LEN_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	localparam int CFG_W = (LEN_BITS + 1 > LEVEL_FRAC_BITS + 1) ?
		LEN_BITS + 1 : LEVEL_FRAC_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           start_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [LEVEL_FRAC_BITS:0]       level,
	output logic                           last,
	output logic [2:0]                     phase
);
	import adsr_pkg::*;

	logic [LEN_BITS-1:0]      attack_len, decay_len, release_len;
	logic [LEVEL_FRAC_BITS:0] sustain_eff;
	logic [LEN_BITS:0]        frame_eff;
	ctrl_t                    ctrl;
	status_t                  status;

	adsr_cfg_regs #(
		.LEN_BITS        (LEN_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
		.CFG_W           (CFG_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.attack_len  (attack_len),
		.decay_len   (decay_len),
		.release_len (release_len),
		.sustain_eff (sustain_eff),
		.frame_eff   (frame_eff)
	);

	adsr_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctrl     (ctrl)
	);

	adsr_datapath #(
		.LEN_BITS        (LEN_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.start_req   (start_req),
		.attack_len  (attack_len),
		.decay_len   (decay_len),
		.release_len (release_len),
		.sustain_eff (sustain_eff),
		.frame_eff   (frame_eff),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.level       (level),
		.last        (last),
		.phase       (phase)
	);

	assign in_ready = ctrl.w.act == ACT_LOAD;

endmodule

FILE: rtl/core/adsr_checker.sv
module adsr_checker #(
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [LEVEL_FRAC_BITS:0] level,
	input logic                     last,
	input logic [2:0]               phase
);
	import adsr_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(last)
			&& $stable(phase))
		else $error("result changed while stalled");

	// one sample in flight: drop ready right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_TAIL |-> level == '0)
		else $error("tail sample not zero");

	a_attack_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_ATTACK |-> !level[LEVEL_FRAC_BITS])
		else $error("attack sample reached full scale");

endmodule

bind adsr_envelope_generator adsr_checker #(
	.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_adsr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level     (level),
	.last      (last),
	.phase     (phase)
);
